// File: rtl/ssd_pkg.sv
package ssd_pkg;

  localparam int unsigned MAX_DIGITS_DEF     = 8;
  localparam int unsigned BLINK_PRESCALE_DEF = 50;

  localparam int unsigned SEG_W      = 8;
  localparam int unsigned SEL_W      = 8;
  localparam int unsigned SEL_IDX_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned PRESCALE_W = 6;
  localparam int unsigned BLINK_W    = 8;
  localparam int unsigned TEXT_W     = 4;

  localparam logic [LEVEL_W-1:0] TOP_LEVEL = 4'd9;
  localparam logic [SEG_W-1:0]   POINT_BIT = 8'h80;
  localparam logic [7:0]         CHAR_DOT  = 8'h2E;

  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_SPEED    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MASK     = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_CHAR,
    OP_DOT
  } op_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    clamp_level = (v > TOP_LEVEL) ? TOP_LEVEL : v;
  endfunction

  // dark slots after the fitted digits, per contrast level
  function automatic logic [7:0] dark_slots(input logic [LEVEL_W-1:0] lvl);
    case (lvl)
      4'd0:    dark_slots = 8'd200;
      4'd1:    dark_slots = 8'd100;
      4'd2:    dark_slots = 8'd50;
      4'd3:    dark_slots = 8'd25;
      4'd4:    dark_slots = 8'd15;
      4'd5:    dark_slots = 8'd10;
      4'd6:    dark_slots = 8'd8;
      4'd7:    dark_slots = 8'd6;
      4'd8:    dark_slots = 8'd4;
      default: dark_slots = 8'd0;
    endcase
  endfunction

  // (9 - speed) * 20 as shift-add
  function automatic logic [BLINK_W-1:0] blink_limit(input logic [LEVEL_W-1:0] speed);
    logic [LEVEL_W-1:0] d;
    d = TOP_LEVEL - clamp_level(speed);
    blink_limit = {d, 4'b0000} + {2'b00, d, 2'b00};
  endfunction

  function automatic logic [SEG_W-1:0] font_of(input logic [7:0] c);
    case (c)
      "0":     font_of = 8'h3F;
      "1":     font_of = 8'h06;
      "2":     font_of = 8'h5B;
      "3":     font_of = 8'h4F;
      "4":     font_of = 8'h66;
      "5":     font_of = 8'h6D;
      "6":     font_of = 8'h7D;
      "7":     font_of = 8'h07;
      "8":     font_of = 8'h7F;
      "9":     font_of = 8'h67;
      "a":     font_of = 8'h77;
      "b":     font_of = 8'h7C;
      "c":     font_of = 8'h39;
      "d":     font_of = 8'h5E;
      "e":     font_of = 8'h7B;
      "E":     font_of = 8'h79;
      "f":     font_of = 8'h71;
      "g":     font_of = 8'h6F;
      "-":     font_of = 8'h40;
      "h":     font_of = 8'h76;
      "o":     font_of = 8'h5C;
      "l":     font_of = 8'h38;
      "p":     font_of = 8'h73;
      default: font_of = 8'h00;
    endcase
  endfunction

endpackage

// File: rtl/ssd_in_if.sv
interface ssd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] character;
  logic       first;

  modport source (output valid, output kind, output character, output first, input ready);
  modport sink (input valid, input kind, input character, input first, output ready);
endinterface

// File: rtl/ssd_out_if.sv
interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_select;
  logic [7:0] segment_bits;

  modport source (output valid, output digit_select, output segment_bits, input ready);
  modport sink (input valid, input digit_select, input segment_bits, output ready);
endinterface

// File: rtl/ssd_seg_store.sv
module ssd_seg_store #(
  parameter int unsigned DEPTH = ssd_pkg::MAX_DIGITS_DEF,
  parameter int unsigned AW    = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [ssd_pkg::SEG_W-1:0] wr_data,
  output logic [ssd_pkg::SEG_W-1:0] rd_data
);

  logic [ssd_pkg::SEG_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          written_r;
  logic [ssd_pkg::SEG_W-1:0] rdata_r;
  logic                      rvalid_r;
  logic                      fwd_hit_r;
  logic [ssd_pkg::SEG_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // entries never written read as dark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rvalid_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_r  <= written_r[rd_addr];
        // same-cycle write to the entry being read: take the new value
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      rd_data = fwd_data_r;
    end else if (rvalid_r) begin
      rd_data = rdata_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// File: rtl/seven_segment_scan_driver_core.sv
// Multiplexed seven-segment scan driver.
// Input channel in_chan carries items: kind 0 is a scan tick, kind 1 a text
// character (first restarts text at digit zero). Each tick produces exactly
// one transfer on out_chan with a one-hot or all-zero digit_select and its
// segment_bits; characters produce no result and only update the segment store.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) for
// position count, contrast level, blink speed and blink mask; write it only
// while the block is idle.
// The segment store is read at the tick's input transfer and the output
// register loads the read data when the read stage advances. Throughput is
// one item per cycle unless a tick waits on a stalled output register; the
// single port pair of the segment store is shared by the tick read, the dot
// read-modify-write and the character write; same-entry accesses are forwarded.
// Reset (synchronous, rst_n low) restores the register defaults, blanks all
// digits and clears the scan and blink counters; no clearing pass is needed.
// When the receiver stalls, the output register holds its result; characters
// keep flowing and one more tick is taken into the read stage, after which
// in_chan stalls for every item until the output register frees.
module seven_segment_scan_driver_core #(
  parameter int unsigned MAX_DIGITS     = ssd_pkg::MAX_DIGITS_DEF,
  parameter int unsigned BLINK_PRESCALE = ssd_pkg::BLINK_PRESCALE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ssd_in_if.sink                        in_chan,
  ssd_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [ssd_pkg::LEVEL_W-1:0] MAX_CNT = ssd_pkg::LEVEL_W'(MAX_DIGITS);
  localparam logic [ssd_pkg::PRESCALE_W-1:0] PRESCALE_END =
    ssd_pkg::PRESCALE_W'(BLINK_PRESCALE);

  // configuration
  logic [ssd_pkg::LEVEL_W-1:0] position_count_r;
  logic [ssd_pkg::LEVEL_W-1:0] contrast_level_r;
  logic [ssd_pkg::LEVEL_W-1:0] blink_speed_r;
  logic [ssd_pkg::SEL_W-1:0]   blink_mask_r;

  // scan and text state
  logic [ssd_pkg::SLOT_W-1:0]     scan_slot_r, scan_slot_nxt;
  logic [ssd_pkg::SEL_W-1:0]      enable_mask_r, enable_mask_nxt;
  logic [ssd_pkg::PRESCALE_W-1:0] blink_prescale_r, blink_prescale_nxt;
  logic [ssd_pkg::BLINK_W-1:0]    blink_counter_r, blink_counter_nxt;
  logic [ssd_pkg::TEXT_W-1:0]     text_index_r, text_index_nxt;

  // read stage
  logic                      s1_valid_r, s1_valid_nxt;
  ssd_pkg::op_t              s1_op_r, s1_op_nxt;
  logic [ssd_pkg::SEL_W-1:0] s1_sel_r, s1_sel_nxt;
  logic [ssd_pkg::SEG_W-1:0] s1_font_r, s1_font_nxt;
  logic [AW-1:0]             s1_addr_r, s1_addr_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [ssd_pkg::SEL_W-1:0] out_sel_r, out_sel_nxt;
  logic [ssd_pkg::SEG_W-1:0] out_seg_r, out_seg_nxt;

  logic                        accept;
  logic                        s1_adv;
  logic [ssd_pkg::LEVEL_W-1:0]  count;
  logic [ssd_pkg::TEXT_W-1:0]   ti_eff;
  logic                        lit;
  logic [ssd_pkg::SEL_W-1:0]   tick_sel;
  logic [ssd_pkg::SLOT_W:0]    slot_limit;
  logic [ssd_pkg::SLOT_W:0]    slot_inc;
  logic [ssd_pkg::PRESCALE_W-1:0] prescale_inc;
  logic [ssd_pkg::BLINK_W-1:0] counter_inc;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic                        wr_en;
  logic [ssd_pkg::SEG_W-1:0]   wr_data;
  logic [ssd_pkg::SEG_W-1:0]   rd_data;

  assign count  = (position_count_r > MAX_CNT) ? MAX_CNT : position_count_r;
  assign s1_adv = s1_valid_r &&
                  ((s1_op_r != ssd_pkg::OP_TICK) || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign accept = in_chan.valid && in_chan.ready;
  assign ti_eff = in_chan.first ? '0 : text_index_r;

  assign lit = ({4'b0000, count} > scan_slot_r) &&
               enable_mask_r[scan_slot_r[ssd_pkg::SEL_IDX_W-1:0]];
  assign tick_sel = lit ? (ssd_pkg::SEL_W'(1) << scan_slot_r[ssd_pkg::SEL_IDX_W-1:0]) : '0;
  assign slot_limit = {1'b0, ssd_pkg::dark_slots(ssd_pkg::clamp_level(contrast_level_r))} +
                      {5'b00000, count};
  assign slot_inc     = {1'b0, scan_slot_r} + 9'd1;
  assign prescale_inc = blink_prescale_r + 6'd1;
  assign counter_inc  = blink_counter_r + 8'd1;

  // stage 0: decode item, advance counters, issue store read
  always_comb begin
    scan_slot_nxt      = scan_slot_r;
    enable_mask_nxt    = enable_mask_r;
    blink_prescale_nxt = blink_prescale_r;
    blink_counter_nxt  = blink_counter_r;
    text_index_nxt     = text_index_r;
    s1_op_nxt          = ssd_pkg::OP_TICK;
    s1_sel_nxt         = tick_sel;
    s1_font_nxt        = ssd_pkg::font_of(in_chan.character);
    s1_addr_nxt        = scan_slot_r[AW-1:0];
    s1_valid_nxt       = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = scan_slot_r[AW-1:0];

    if (accept) begin
      if (!in_chan.kind) begin
        s1_valid_nxt  = 1'b1;
        rd_en         = 1'b1;
        scan_slot_nxt = (slot_inc > slot_limit) ? '0 : slot_inc[ssd_pkg::SLOT_W-1:0];
        if (prescale_inc >= PRESCALE_END) begin
          blink_prescale_nxt = '0;
          if (blink_mask_r != '0) begin
            if (counter_inc > ssd_pkg::blink_limit(blink_speed_r)) begin
              blink_counter_nxt = '0;
              enable_mask_nxt   = enable_mask_r ^ blink_mask_r;
            end else begin
              blink_counter_nxt = counter_inc;
            end
          end
        end else begin
          blink_prescale_nxt = prescale_inc;
        end
      end else begin
        text_index_nxt = ti_eff;
        if (in_chan.character == ssd_pkg::CHAR_DOT) begin
          // point goes on the previous digit; drop a leading dot
          if (ti_eff != '0) begin
            s1_valid_nxt = 1'b1;
            s1_op_nxt    = ssd_pkg::OP_DOT;
            s1_addr_nxt  = AW'(ti_eff - 4'd1);
            rd_en        = 1'b1;
            rd_addr      = AW'(ti_eff - 4'd1);
          end
        end else if (ti_eff < count) begin
          s1_valid_nxt   = 1'b1;
          s1_op_nxt      = ssd_pkg::OP_CHAR;
          s1_addr_nxt    = AW'(ti_eff);
          text_index_nxt = ti_eff + 4'd1;
        end
      end
    end else if (s1_valid_r && !s1_adv) begin
      s1_valid_nxt = 1'b1;
    end

    // hold the stalled stage
    if (s1_valid_r && !s1_adv) begin
      s1_op_nxt   = s1_op_r;
      s1_sel_nxt  = s1_sel_r;
      s1_font_nxt = s1_font_r;
      s1_addr_nxt = s1_addr_r;
    end

    if (cfg_we && (cfg_index == ssd_pkg::CFG_BLINK_MASK)) begin
      enable_mask_nxt = '1;
    end
  end

  // stage 1: write back characters and points, hand ticks to the output
  assign wr_en   = s1_valid_r && (s1_op_r != ssd_pkg::OP_TICK);
  assign wr_data = (s1_op_r == ssd_pkg::OP_DOT) ? (rd_data | ssd_pkg::POINT_BIT) : s1_font_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sel_nxt   = out_sel_r;
    out_seg_nxt   = out_seg_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv && (s1_op_r == ssd_pkg::OP_TICK)) begin
      out_valid_nxt = 1'b1;
      out_sel_nxt   = s1_sel_r;
      out_seg_nxt   = (s1_sel_r != '0) ? rd_data : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.digit_select = out_sel_r;
  assign out_chan.segment_bits = out_seg_r;

  ssd_seg_store #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_seg_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_count_r <= 4'd8;
      contrast_level_r <= 4'd9;
      blink_speed_r    <= 4'd5;
      blink_mask_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssd_pkg::CFG_POSITION_COUNT: position_count_r <= cfg_wdata[ssd_pkg::LEVEL_W-1:0];
        ssd_pkg::CFG_CONTRAST_LEVEL: contrast_level_r <= cfg_wdata[ssd_pkg::LEVEL_W-1:0];
        ssd_pkg::CFG_BLINK_SPEED:    blink_speed_r    <= cfg_wdata[ssd_pkg::LEVEL_W-1:0];
        ssd_pkg::CFG_BLINK_MASK:     blink_mask_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_slot_r      <= '0;
      enable_mask_r    <= '1;
      blink_prescale_r <= '0;
      blink_counter_r  <= '0;
      text_index_r     <= '0;
      s1_valid_r       <= 1'b0;
      s1_op_r          <= ssd_pkg::OP_TICK;
      out_valid_r      <= 1'b0;
    end else begin
      scan_slot_r      <= scan_slot_nxt;
      enable_mask_r    <= enable_mask_nxt;
      blink_prescale_r <= blink_prescale_nxt;
      blink_counter_r  <= blink_counter_nxt;
      text_index_r     <= text_index_nxt;
      s1_valid_r       <= s1_valid_nxt;
      s1_op_r          <= s1_op_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_sel_r  <= s1_sel_nxt;
    s1_font_r <= s1_font_nxt;
    s1_addr_r <= s1_addr_nxt;
    out_sel_r <= out_sel_nxt;
    out_seg_r <= out_seg_nxt;
  end

endmodule

// File: sim/tb_seven_segment_scan_driver_core.sv
module tb_seven_segment_scan_driver_core;

  localparam logic        KIND_TICK   = 1'b0;
  localparam logic        KIND_CHAR   = 1'b1;
  localparam int unsigned BLINK_STEP  = 20;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int unsigned DARK_AFTER [10] = '{200, 100, 50, 25, 15, 10, 8, 6, 4, 0};

  typedef enum logic [1:0] {
    DO_TICK,
    DO_CHAR,
    DO_REG
  } step_t;

  typedef struct packed {
    step_t      what;
    logic [1:0] idx;
    logic [7:0] val;
    logic       first;
    logic       typed;
    logic [7:0] t_sel;
    logic [7:0] t_seg;
  } row_t;

  typedef struct packed {
    logic [3:0] pos;
    logic [3:0] con;
    logic [3:0] spd;
    logic [7:0] blinkers;
    logic [6:0] gap;
    logic [6:0] stall;
  } phase_t;

  typedef struct packed {
    logic [7:0] sel;
    logic [7:0] seg;
  } lit_t;

  // after reset: 8 digits, no dark slots, so the scan runs over slots 0..8
  localparam row_t SCRIPT [25] = '{
    '{DO_TICK, '0, 8'h00,             1'b0, 1'b1, 8'h01, 8'h00},
    '{DO_CHAR, '0, ssd_pkg::CHAR_DOT, 1'b1, 1'b0, 8'h00, 8'h00},
    '{DO_CHAR, '0, "8",               1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_CHAR, '0, ssd_pkg::CHAR_DOT, 1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_CHAR, '0, 8'h00,             1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_CHAR, '0, 8'hFF,             1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_CHAR, '0, "p",               1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_CHAR, '0, "-",               1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_CHAR, '0, "E",               1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_CHAR, '0, "0",               1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_CHAR, '0, "9",               1'b0, 1'b0, 8'h00, 8'h00},
    // past the last digit: dropped, then a dot lands on the last digit
    '{DO_CHAR, '0, "1",               1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_CHAR, '0, ssd_pkg::CHAR_DOT, 1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_TICK, '0, 8'hFF,             1'b1, 1'b0, 8'h00, 8'h00},
    '{DO_TICK, '0, 8'h00,             1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_TICK, '0, 8'h00,             1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_TICK, '0, 8'h00,             1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_TICK, '0, 8'h00,             1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_TICK, '0, 8'h00,             1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_TICK, '0, 8'h00,             1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_TICK, '0, 8'h00,             1'b0, 1'b1, 8'h00, 8'h00},
    '{DO_TICK, '0, 8'h00,             1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_REG,  ssd_pkg::CFG_POSITION_COUNT, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
    '{DO_TICK, '0, 8'h00,             1'b0, 1'b1, 8'h00, 8'h00},
    '{DO_REG,  ssd_pkg::CFG_POSITION_COUNT, 8'hF8, 1'b0, 1'b0, 8'h00, 8'h00}
  };

  localparam phase_t PHASES [8] = '{
    '{4'd8,  4'd9,  4'd9,  8'hA5, 7'd0,  7'd0},
    '{4'd1,  4'd0,  4'd0,  8'hFF, 7'd84, 7'd0},
    '{4'd15, 4'd15, 4'd15, 8'h0F, 7'd0,  7'd84},
    '{4'd0,  4'd8,  4'd9,  8'hFF, 7'd33, 7'd33},
    '{4'd3,  4'd5,  4'd9,  8'h00, 7'd0,  7'd0},
    '{4'd9,  4'd9,  4'd9,  8'h5A, 7'd84, 7'd0},
    '{4'd5,  4'd2,  4'd8,  8'h3C, 7'd0,  7'd84},
    '{4'd8,  4'd9,  4'd9,  8'h81, 7'd33, 7'd33}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  ssd_in_if  in_if ();
  ssd_out_if out_if ();

  seven_segment_scan_driver_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copy and display state of the predictor
  logic [3:0]  set_pos;
  logic [3:0]  set_contrast;
  logic [3:0]  set_speed;
  logic [7:0]  set_blinkers;
  logic [7:0]  slot_now;
  logic [7:0]  shown_mask;
  logic [5:0]  tick_div;
  logic [7:0]  blink_steps;
  logic [7:0]  glyph_store [8];
  int unsigned text_pos;

  lit_t  drive_q [$];
  int    mismatches = 0;
  int    cycles = 0;
  int    gap_pct = 0;
  int    stall_pct = 0;
  string glyphs = "0123456789abcdeEfg-holp";

  task automatic advance_display(input logic kind, input logic [7:0] ch, input logic first,
                                 output bit lit, output lit_t drive);
    int unsigned fitted;
    int unsigned last_slot;
    int unsigned speed_lvl;
    int unsigned hold_steps;
    logic [7:0]  nxt;
    logic [7:0]  pattern;
    fitted = (set_pos > ssd_pkg::MAX_DIGITS_DEF) ? ssd_pkg::MAX_DIGITS_DEF : set_pos;
    lit = 1'b0;
    drive = '0;
    if (kind == KIND_CHAR) begin
      if (first) text_pos = 0;
      if (ch == ssd_pkg::CHAR_DOT) begin
        if (text_pos > 0 && text_pos <= ssd_pkg::MAX_DIGITS_DEF)
          glyph_store[3'(text_pos - 1)] = glyph_store[3'(text_pos - 1)] | ssd_pkg::POINT_BIT;
      end else if (text_pos < fitted) begin
        case (ch)
          "0":     pattern = 8'h3F;
          "1":     pattern = 8'h06;
          "2":     pattern = 8'h5B;
          "3":     pattern = 8'h4F;
          "4":     pattern = 8'h66;
          "5":     pattern = 8'h6D;
          "6":     pattern = 8'h7D;
          "7":     pattern = 8'h07;
          "8":     pattern = 8'h7F;
          "9":     pattern = 8'h67;
          "a":     pattern = 8'h77;
          "b":     pattern = 8'h7C;
          "c":     pattern = 8'h39;
          "d":     pattern = 8'h5E;
          "e":     pattern = 8'h7B;
          "E":     pattern = 8'h79;
          "f":     pattern = 8'h71;
          "g":     pattern = 8'h6F;
          "-":     pattern = 8'h40;
          "h":     pattern = 8'h76;
          "o":     pattern = 8'h5C;
          "l":     pattern = 8'h38;
          "p":     pattern = 8'h73;
          default: pattern = 8'h00;
        endcase
        glyph_store[3'(text_pos)] = pattern;
        text_pos++;
      end
    end else begin
      lit = 1'b1;
      if (slot_now < fitted && shown_mask[slot_now[2:0]]) begin
        drive.sel = 8'd1 << slot_now[2:0];
        drive.seg = glyph_store[slot_now[2:0]];
      end
      last_slot = DARK_AFTER[(set_contrast > ssd_pkg::TOP_LEVEL) ? ssd_pkg::TOP_LEVEL :
                                                                 set_contrast] + fitted;
      nxt = slot_now + 8'd1;
      slot_now = (nxt > last_slot) ? 8'd0 : nxt;
      tick_div = tick_div + 6'd1;
      if (tick_div >= ssd_pkg::BLINK_PRESCALE_DEF) begin
        tick_div = '0;
        if (set_blinkers != 8'h00) begin
          speed_lvl = 32'((set_speed > ssd_pkg::TOP_LEVEL) ? ssd_pkg::TOP_LEVEL : set_speed);
          hold_steps = (32'(ssd_pkg::TOP_LEVEL) - speed_lvl) * BLINK_STEP;
          blink_steps = blink_steps + 8'd1;
          if (blink_steps > hold_steps) begin
            blink_steps = '0;
            shown_mask = shown_mask ^ set_blinkers;
          end
        end
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      ssd_pkg::CFG_POSITION_COUNT: set_pos = val[3:0];
      ssd_pkg::CFG_CONTRAST_LEVEL: set_contrast = val[3:0];
      ssd_pkg::CFG_BLINK_SPEED:    set_speed = val[3:0];
      ssd_pkg::CFG_BLINK_MASK: begin
        set_blinkers = val;
        shown_mask = 8'hFF;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // a char leaves nothing to wait on, so let the pipe drain once the queue runs dry
  task automatic settle();
    in_if.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic feed(input logic kind, input logic [7:0] ch, input logic first,
                      input logic typed, input logic [7:0] t_sel, input logic [7:0] t_seg);
    logic took;
    bit   lit;
    lit_t drive;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.character <= ch;
    in_if.first <= first;
    // sample ready once it has settled, the transfer happens at the following edge
    do begin
      @(negedge clk);
      took = in_if.ready;
      @(posedge clk);
    end while (!took);
    advance_display(kind, ch, first, lit, drive);
    if (typed) begin
      drive.sel = t_sel;
      drive.seg = t_seg;
    end
    if (lit) drive_q.push_back(drive);
  endtask

  initial begin
    out_if.ready = 1'b1;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(negedge clk) begin
    lit_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected transfer, digit_select %h segment_bits %h",
                 $time, out_if.digit_select, out_if.segment_bits);
        mismatches++;
      end else begin
        want = drive_q.pop_front();
        if (out_if.digit_select !== want.sel) begin
          $display("%0t: digit_select expected %h got %h", $time, want.sel,
                   out_if.digit_select);
          mismatches++;
        end
        if (out_if.segment_bits !== want.seg) begin
          $display("%0t: segment_bits expected %h got %h", $time, want.seg,
                   out_if.segment_bits);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("seven_segment_scan_driver_core verification failed");
      $finish;
    end
  end

  initial begin
    logic       k;
    logic [7:0] c;
    logic       f;
    int         pick;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_TICK;
    in_if.character = 8'h00;
    in_if.first = 1'b0;
    cfg_we = 1'b0;
    cfg_index = ssd_pkg::CFG_POSITION_COUNT;
    cfg_wdata = 8'h00;

    set_pos = 4'd8;
    set_contrast = 4'd9;
    set_speed = 4'd5;
    set_blinkers = 8'h00;
    slot_now = '0;
    shown_mask = 8'hFF;
    tick_div = '0;
    blink_steps = '0;
    foreach (glyph_store[i]) glyph_store[i] = 8'h00;
    text_pos = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (SCRIPT[r]) begin
      if (SCRIPT[r].what == DO_REG) begin
        settle();
        write_reg(SCRIPT[r].idx, SCRIPT[r].val);
      end else begin
        feed((SCRIPT[r].what == DO_CHAR) ? KIND_CHAR : KIND_TICK, SCRIPT[r].val,
             SCRIPT[r].first, SCRIPT[r].typed, SCRIPT[r].t_sel, SCRIPT[r].t_seg);
      end
    end

    foreach (PHASES[p]) begin
      settle();
      // upper bits of the narrow registers carry junk that must be dropped
      write_reg(ssd_pkg::CFG_POSITION_COUNT, {4'($urandom_range(15)), PHASES[p].pos});
      write_reg(ssd_pkg::CFG_CONTRAST_LEVEL, {4'($urandom_range(15)), PHASES[p].con});
      write_reg(ssd_pkg::CFG_BLINK_SPEED, {4'($urandom_range(15)), PHASES[p].spd});
      write_reg(ssd_pkg::CFG_BLINK_MASK, PHASES[p].blinkers);
      gap_pct = 32'(PHASES[p].gap);
      stall_pct = 32'(PHASES[p].stall);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 65) begin
          k = KIND_TICK;
          c = 8'($urandom_range(255));
          f = 1'($urandom_range(1));
        end else begin
          k = KIND_CHAR;
          f = ($urandom_range(7) == 0);
          pick = $urandom_range(9);
          if (pick < 6) c = glyphs[$urandom_range(glyphs.len() - 1)];
          else if (pick < 8) c = ssd_pkg::CHAR_DOT;
          else c = 8'($urandom_range(255));
        end
        feed(k, c, f, 1'b0, 8'h00, 8'h00);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("seven_segment_scan_driver_core verification clean");
    end else begin
      $display("seven_segment_scan_driver_core verification failed");
    end
    $finish;
  end

endmodule
